// ===== design/pfe_pkg.sv =====
// shared widths, letter codes, key square types and reset key for the playfair encryptor
package pfe_pkg;

    localparam int SIDE     = 5;
    localparam int CODE_W   = 5;
    localparam int POS_W    = 3;
    localparam int ROW_W    = SIDE * CODE_W;
    localparam int CHAR_W   = 8;
    localparam int CIPHER_W = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [ROW_W-1:0]    t_key_row;
    typedef logic [SIDE-1:0][ROW_W-1:0] t_key_sq;
    typedef logic [CIPHER_W-1:0] t_cipher;

    // letter codes, A is zero
    localparam t_code CODE_X = t_code'(23);
    localparam t_code CODE_J = t_code'(9);
    localparam t_code CODE_I = t_code'(8);

    // square MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
    localparam t_key_row KEY_ROW_0_RST = t_key_row'(10755244);
    localparam t_key_row KEY_ROW_1_RST = t_key_row'(17283508);
    localparam t_key_row KEY_ROW_2_RST = t_key_row'(25942713);
    localparam t_key_row KEY_ROW_3_RST = t_key_row'(6848868);
    localparam t_key_row KEY_ROW_4_RST = t_key_row'(2149955);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_4 = 3'd4;

    // ascii of uppercase A
    localparam t_cipher ASCII_A = t_cipher'(65);

endpackage

// ===== design/pfe_if.sv =====
// stream and configuration channel interfaces for the playfair encryptor

// plaintext words
interface pfe_in_if;
    logic                         valid;
    logic                         ready;
    logic [pfe_pkg::CHAR_W-1:0]   in_char;
    logic                         end_of_text;
    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

// ciphertext pair words
interface pfe_out_if;
    logic              valid;
    logic              ready;
    pfe_pkg::t_cipher  cipher_first;
    pfe_pkg::t_cipher  cipher_second;
    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

// register write words
interface pfe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfe_pkg::CFG_IDX_W-1:0]  index;
    pfe_pkg::t_key_row              data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/playfair_stream_encrypt_unit.sv =====
// top level of the playfair stream encryptor: letter pairing, key registers, output stage
// One plaintext word is accepted every cycle; ready drops only when both the pair
// register and the output register hold words and the output side is stalled.
// A word that completes a digraph (a second letter, a doubled letter, or end of text
// with a letter pending) comes out as one ciphertext pair: folding and pairing go into
// the pair register, then the key square lookup and the playfair rules go into the
// output register. Other words give no result.
// Key rows are written through the configuration channel, which is always ready; a write
// to an index beyond row 4 is dropped. Keys must be written only while the block is idle.
module playfair_stream_encrypt_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfe_in_if.sink     i_in,
    pfe_out_if.source  o_out,
    pfe_cfg_if.sink    i_cfg
);
    import pfe_pkg::*;

    t_key_sq r_key;
    logic    r_pend_valid, n_pend_valid;
    t_code   r_pend_letter, n_pend_letter;
    logic    r_pair_valid;
    t_code   r_pair_first, r_pair_second;
    t_code   n_pair_first, n_pair_second;
    logic    n_pair_emit;
    logic    r_out_valid;
    t_cipher r_out_first, r_out_second;
    t_cipher ciph_first, ciph_second;
    logic    in_accept, pair_move, is_upper, is_lower;
    t_code   letter;

    // key row writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY_ROW_0_RST;
            r_key[1] <= KEY_ROW_1_RST;
            r_key[2] <= KEY_ROW_2_RST;
            r_key[3] <= KEY_ROW_3_RST;
            r_key[4] <= KEY_ROW_4_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KEY_ROW_0: r_key[0] <= i_cfg.data;
                REG_KEY_ROW_1: r_key[1] <= i_cfg.data;
                REG_KEY_ROW_2: r_key[2] <= i_cfg.data;
                REG_KEY_ROW_3: r_key[3] <= i_cfg.data;
                REG_KEY_ROW_4: r_key[4] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign pair_move  = r_pair_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_pair_valid || pair_move;
    assign in_accept  = i_in.valid && i_in.ready;

    // fold case and map J to I
    assign is_upper = (i_in.in_char >= 8'd65) && (i_in.in_char <= 8'd90);
    assign is_lower = (i_in.in_char >= 8'd97) && (i_in.in_char <= 8'd122);

    always_comb begin
        if (is_lower) begin
            letter = t_code'(i_in.in_char - 8'd97);
        end else begin
            letter = t_code'(i_in.in_char - 8'd65);
        end
        if (letter == CODE_J) begin
            letter = CODE_I;
        end
    end

    // digraph forming
    always_comb begin
        n_pend_valid  = r_pend_valid;
        n_pend_letter = r_pend_letter;
        n_pair_emit   = 1'b0;
        n_pair_first  = r_pend_letter;
        n_pair_second = CODE_X;
        if (i_in.end_of_text) begin
            if (r_pend_valid) begin
                n_pair_emit   = 1'b1;
                n_pend_valid  = 1'b0;
                n_pend_letter = '0;
            end
        end else if (is_upper || is_lower) begin
            if (!r_pend_valid) begin
                n_pend_valid  = 1'b1;
                n_pend_letter = letter;
            end else if (letter == r_pend_letter) begin
                n_pair_emit = 1'b1;
            end else begin
                n_pair_emit   = 1'b1;
                n_pair_second = letter;
                n_pend_valid  = 1'b0;
                n_pend_letter = '0;
            end
        end
    end

    // pending letter and pair register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_pend_letter <= '0;
            r_pair_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_pend_valid  <= n_pend_valid;
                r_pend_letter <= n_pend_letter;
                r_pair_valid  <= n_pair_emit;
            end else if (pair_move) begin
                r_pair_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_pair_emit) begin
            r_pair_first  <= n_pair_first;
            r_pair_second <= n_pair_second;
        end
    end

    // key square lookup and encipher
    pfe_cipher u_cipher (
        .i_key    (r_key),
        .i_first  (r_pair_first),
        .i_second (r_pair_second),
        .o_first  (ciph_first),
        .o_second (ciph_second)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pair_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_move) begin
            r_out_first  <= ciph_first;
            r_out_second <= ciph_second;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.cipher_first  = r_out_first;
    assign o_out.cipher_second = r_out_second;

endmodule

// ===== design/pfe_cipher.sv =====
// playfair digraph encipher: key square lookup and row, column, rectangle rules
module pfe_cipher (
    input  pfe_pkg::t_key_sq i_key,
    input  pfe_pkg::t_code   i_first,
    input  pfe_pkg::t_code   i_second,
    output pfe_pkg::t_cipher o_first,
    output pfe_pkg::t_cipher o_second
);
    import pfe_pkg::*;

    t_pos  ra, ca, rb, cb;
    t_pos  sel_ra, sel_ca, sel_rb, sel_cb;
    t_code code_a, code_b;

    // wrap to the next row or column
    function automatic t_pos next_pos(input t_pos p);
        next_pos = (p == t_pos'(SIDE - 1)) ? '0 : p + t_pos'(1);
    endfunction

    // locate both letters, first match in row-major order wins, no match is 0,0
    always_comb begin
        ra = '0;
        ca = '0;
        rb = '0;
        cb = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (i_key[r][c*CODE_W +: CODE_W] == i_first) begin
                    ra = t_pos'(r);
                    ca = t_pos'(c);
                end
                if (i_key[r][c*CODE_W +: CODE_W] == i_second) begin
                    rb = t_pos'(r);
                    cb = t_pos'(c);
                end
            end
        end
    end

    // pick the output cells by the playfair rules
    always_comb begin
        if (ra == rb) begin
            sel_ra = ra;
            sel_ca = next_pos(ca);
            sel_rb = rb;
            sel_cb = next_pos(cb);
        end else if (ca == cb) begin
            sel_ra = next_pos(ra);
            sel_ca = ca;
            sel_rb = next_pos(rb);
            sel_cb = cb;
        end else begin
            sel_ra = ra;
            sel_ca = cb;
            sel_rb = rb;
            sel_cb = ca;
        end
    end

    assign code_a = i_key[sel_ra][sel_ca*CODE_W +: CODE_W];
    assign code_b = i_key[sel_rb][sel_cb*CODE_W +: CODE_W];

    // codes to ascii, codes above Z pass through as 91..96
    assign o_first  = ASCII_A + t_cipher'(code_a);
    assign o_second = ASCII_A + t_cipher'(code_b);

endmodule
